FILE: sv/glzw_pkg.sv
// Shared types, constants and helpers for the GIF LZW encoder.
// Used by glzw_packer and gif_lzw_encoder; depends on nothing else.
package glzw_pkg;

    localparam int CODE_W      = 12;
    localparam int PIX_W       = 8;
    localparam int MCS_W       = 4;
    localparam int WIDTH_W     = 4;
    localparam int IDX_W       = CODE_W + PIX_W;
    localparam int DICT_CODES  = 4096;
    localparam int CHILD_DEPTH = DICT_CODES * (1 << PIX_W);
    localparam int ACC_W       = 32;
    localparam int ACC_BYTES   = ACC_W / 8;
    localparam int CNT_W       = 6;

    localparam logic [CODE_W-1:0]  MAX_CODE   = CODE_W'(DICT_CODES - 1);
    localparam logic [MCS_W-1:0]   MCS_RESET  = 4'd8;
    localparam logic [MCS_W-1:0]   MCS_MIN    = 4'd2;
    localparam logic [MCS_W-1:0]   MCS_MAX    = 4'd8;
    localparam logic [WIDTH_W-1:0] WIDTH_MIN  = 4'd3;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX  = 4'd12;
    localparam logic [7:0]         SUB_LEN    = 8'd255;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHILD,
        ST_OWNER,
        ST_MISS,
        ST_FULL,
        ST_START,
        ST_E_CUR,
        ST_E_CLR,
        ST_E_END
    } eng_state_t;

    // one code handed from the dictionary engine to the bit packer
    typedef struct packed {
        logic [CODE_W-1:0]  value;
        logic [WIDTH_W-1:0] width;
        logic               last;  // last code caused by this pixel
        logic               eof;   // end code of the frame, pad after it
    } code_t;

    function automatic logic [MCS_W-1:0] clamp_mcs(input logic [MCS_W-1:0] v);
        logic [MCS_W-1:0] r;
        r = v;
        if (v < MCS_MIN) begin
            r = MCS_MIN;
        end else if (v > MCS_MAX) begin
            r = MCS_MAX;
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] pix_mask(input logic [MCS_W-1:0] mcs);
        logic [PIX_W:0] t;
        t = (PIX_W+1)'(1) << mcs;
        t = t - (PIX_W+1)'(1);
        return t[PIX_W-1:0];
    endfunction

endpackage

FILE: sv/gif_lzw_encoder.sv
// GIF LZW encoder top level: dictionary engine, child and owner tables,
// input buffer and config register. Depends on glzw_pkg and glzw_packer.
//
// Pixels enter on s_ (valid/ready), one palette index per transfer, with
// s_end_of_image on the last pixel of a frame. Packed code bytes leave on
// m_ (valid/ready), LSB first, with sub-block end, stream end and a flag on
// the last byte caused by each pixel. cfg_min_code_size is written on its
// own valid/ready channel (always ready) and is latched at frame start.
// Each pixel after the first of a frame takes two dependent single-port
// reads (child table, then the owner table that validates the child
// entry) before a hit is known; a miss adds a state that pushes a code,
// and dictionary restart and end of frame add a state for each extra
// code. A 32-bit bit accumulator and an output register sit between
// engine and m_; when m_ready stays low they fill, code pushes stall,
// and s_ready drops.
// Reset: min code size 8, no frame open. Table memories are not cleared;
// an entry counts only if its code is inside the live code range and the
// owner table maps that code back to the entry, so no clearing pass runs.
module gif_lzw_encoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [glzw_pkg::PIX_W-1:0]    s_pixel_index,
    input  logic                          s_end_of_image,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_subblock_end,
    output logic                          m_stream_end,
    output logic                          m_run_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [glzw_pkg::MCS_W-1:0]    cfg_min_code_size
);
    import glzw_pkg::*;

    eng_state_t          state_reg, state_next;
    logic                in_vld_reg, in_vld_next;
    logic [PIX_W-1:0]    pix_reg;
    logic                eoi_reg;
    logic [MCS_W-1:0]    mcs_cfg_reg;
    logic [MCS_W-1:0]    act_mcs_reg, act_mcs_next;
    logic [CODE_W-1:0]   cur_code_reg, cur_code_next;
    logic                run_active_reg, run_active_next;
    logic [WIDTH_W-1:0]  code_width_reg, code_width_next;
    logic [CODE_W-1:0]   nfc_reg, nfc_next;

    logic [CODE_W-1:0]   child_mem [0:CHILD_DEPTH-1];
    logic [IDX_W-1:0]    owner_mem [0:DICT_CODES-1];
    logic [CODE_W-1:0]   child_rdata_reg;
    logic [IDX_W-1:0]    owner_rdata_reg;

    logic                child_rd, owner_rd, tbl_wr, done;
    logic                code_valid, code_ready;
    code_t               code_out;

    logic [MCS_W-1:0]    start_mcs;
    logic [CODE_W-1:0]   clear_code;
    logic [PIX_W-1:0]    pix_m;
    logic [IDX_W-1:0]    idx;
    logic [CODE_W-1:0]   nfc_inc;
    logic                width_up, full, hit;
    logic [WIDTH_W-1:0]  mcs_plus1;

    assign cfg_ready  = 1'b1;
    assign s_ready    = !in_vld_reg || done;
    assign start_mcs  = clamp_mcs(mcs_cfg_reg);
    assign clear_code = CODE_W'(1) << act_mcs_reg;
    assign pix_m      = pix_reg & pix_mask(act_mcs_reg);
    assign idx        = {cur_code_reg, pix_m};
    assign nfc_inc    = nfc_reg + CODE_W'(1);
    assign width_up   = {1'b0, nfc_inc} >= ((CODE_W+1)'(1) << code_width_reg);
    assign full       = nfc_inc >= MAX_CODE;
    assign mcs_plus1  = act_mcs_reg + WIDTH_W'(1);
    assign hit        = (child_rdata_reg >= clear_code + CODE_W'(2))
                        && (child_rdata_reg <= nfc_reg)
                        && (owner_rdata_reg == idx);

    always_comb begin
        state_next      = state_reg;
        act_mcs_next    = act_mcs_reg;
        cur_code_next   = cur_code_reg;
        run_active_next = run_active_reg;
        code_width_next = code_width_reg;
        nfc_next        = nfc_reg;
        child_rd        = 1'b0;
        owner_rd        = 1'b0;
        tbl_wr          = 1'b0;
        done            = 1'b0;
        code_valid      = 1'b0;
        code_out        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_vld_reg) begin
                    if (!run_active_reg) begin
                        act_mcs_next    = start_mcs;
                        code_width_next = start_mcs + WIDTH_W'(1);
                        nfc_next        = (CODE_W'(1) << start_mcs) + CODE_W'(1);
                        cur_code_next   = CODE_W'(pix_reg & pix_mask(start_mcs));
                        run_active_next = 1'b1;
                        state_next      = ST_START;
                    end else begin
                        child_rd   = 1'b1;
                        state_next = ST_CHILD;
                    end
                end
            end
            ST_CHILD: begin
                owner_rd   = 1'b1;
                state_next = ST_OWNER;
            end
            ST_OWNER: begin
                if (hit) begin
                    cur_code_next = child_rdata_reg;
                    if (eoi_reg) begin
                        state_next = ST_E_CUR;
                    end else begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS: begin
                code_valid     = 1'b1;
                code_out.value = cur_code_reg;
                code_out.width = code_width_reg;
                code_out.last  = !full && !eoi_reg;
                if (code_ready) begin
                    tbl_wr        = 1'b1;
                    nfc_next      = nfc_inc;
                    cur_code_next = CODE_W'(pix_m);
                    if (width_up) begin
                        code_width_next = code_width_reg + WIDTH_W'(1);
                    end
                    if (full) begin
                        state_next = ST_FULL;
                    end else if (eoi_reg) begin
                        state_next = ST_E_CUR;
                    end else begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FULL: begin
                code_valid     = 1'b1;
                code_out.value = clear_code;
                code_out.width = code_width_reg;
                code_out.last  = !eoi_reg;
                if (code_ready) begin
                    code_width_next = mcs_plus1;
                    nfc_next        = clear_code + CODE_W'(1);
                    if (eoi_reg) begin
                        state_next = ST_E_CUR;
                    end else begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_START: begin
                code_valid     = 1'b1;
                code_out.value = clear_code;
                code_out.width = code_width_reg;
                code_out.last  = !eoi_reg;
                if (code_ready) begin
                    if (eoi_reg) begin
                        state_next = ST_E_CUR;
                    end else begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_E_CUR: begin
                code_valid     = 1'b1;
                code_out.value = cur_code_reg;
                code_out.width = code_width_reg;
                if (code_ready) begin
                    state_next = ST_E_CLR;
                end
            end
            ST_E_CLR: begin
                code_valid     = 1'b1;
                code_out.value = clear_code;
                code_out.width = code_width_reg;
                if (code_ready) begin
                    state_next = ST_E_END;
                end
            end
            ST_E_END: begin
                code_valid     = 1'b1;
                code_out.value = clear_code + CODE_W'(1);
                code_out.width = mcs_plus1;
                code_out.last  = 1'b1;
                code_out.eof   = 1'b1;
                if (code_ready) begin
                    run_active_next = 1'b0;
                    cur_code_next   = '0;
                    code_width_next = mcs_plus1;
                    nfc_next        = clear_code + CODE_W'(1);
                    done            = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (done) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_vld_reg     <= 1'b0;
            mcs_cfg_reg    <= MCS_RESET;
            act_mcs_reg    <= MCS_RESET;
            cur_code_reg   <= '0;
            run_active_reg <= 1'b0;
            code_width_reg <= MCS_RESET + WIDTH_W'(1);
            nfc_reg        <= (CODE_W'(1) << MCS_RESET) + CODE_W'(1);
        end else begin
            state_reg      <= state_next;
            in_vld_reg     <= in_vld_next;
            act_mcs_reg    <= act_mcs_next;
            cur_code_reg   <= cur_code_next;
            run_active_reg <= run_active_next;
            code_width_reg <= code_width_next;
            nfc_reg        <= nfc_next;
            if (cfg_valid && cfg_ready) begin
                mcs_cfg_reg <= cfg_min_code_size;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pix_reg <= s_pixel_index;
            eoi_reg <= s_end_of_image;
        end
    end

    // child table: (code, pixel) -> assigned code
    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            child_mem[idx] <= nfc_inc;
        end
        if (child_rd) begin
            child_rdata_reg <= child_mem[idx];
        end
    end

    // owner table: assigned code -> (code, pixel) it was made for
    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            owner_mem[nfc_inc] <= idx;
        end
        if (owner_rd) begin
            owner_rdata_reg <= owner_mem[child_rdata_reg];
        end
    end

    glzw_packer u_packer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .code_valid     (code_valid),
        .code_ready     (code_ready),
        .code_in        (code_out),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_subblock_end (m_subblock_end),
        .m_stream_end   (m_stream_end),
        .m_run_last     (m_run_last)
    );

    a_owner_after_child: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OWNER |-> $past(state_reg) == ST_CHILD)
        else $error("owner table read without child read");

    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        run_active_reg |-> (code_width_reg >= WIDTH_MIN && code_width_reg <= WIDTH_MAX))
        else $error("code width out of range");

    a_dict_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && run_active_reg) |-> nfc_reg < MAX_CODE)
        else $error("dictionary not restarted at full");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !done) |=> (in_vld_reg && $stable(pix_reg) && $stable(eoi_reg)))
        else $error("buffered pixel lost before use");

endmodule

FILE: sv/glzw_packer.sv
// Bit packer: appends variable width codes LSB first and emits bytes with
// sub-block, stream end and per-pixel last flags. Depends on glzw_pkg.
module glzw_packer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 code_valid,
    output logic                 code_ready,
    input  glzw_pkg::code_t      code_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_subblock_end,
    output logic                 m_stream_end,
    output logic                 m_run_last
);
    import glzw_pkg::*;

    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ACC_BYTES-1:0] lst_reg, lst_next;
    logic [ACC_BYTES-1:0] opn_reg, opn_next;
    logic [ACC_BYTES-1:0] fin_reg, fin_next;
    logic                 grp_open_reg, grp_open_next;
    logic [7:0]           sub_cnt_reg, sub_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 sub_reg, sub_next;
    logic                 send_reg, send_next;
    logic                 rlast_reg, rlast_next;

    logic                 emit, take;
    logic [ACC_W-1:0]     acc1;
    logic [CNT_W-1:0]     cnt1, sum, cnt2;
    logic [ACC_BYTES-1:0] lst1, opn1, fin1, opn_base;
    logic [2:0]           nb1, nb2;
    logic [CODE_W-1:0]    code_m;
    logic [CODE_W:0]      wmask;
    logic [7:0]           sc1;
    logic                 new_b;

    assign code_ready     = (cnt_reg <= CNT_W'(ACC_W - CODE_W));
    assign take           = code_valid && code_ready;
    assign m_valid        = m_valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_subblock_end = sub_reg;
    assign m_stream_end   = send_reg;
    assign m_run_last     = rlast_reg;

    always_comb begin
        // a byte that may still be the last of an open pixel group waits
        emit = (cnt_reg >= CNT_W'(8)) && !(opn_reg[0] && lst_reg[0] && grp_open_reg)
               && (!m_valid_reg || m_ready);

        acc1 = emit ? (acc_reg >> 8) : acc_reg;
        cnt1 = emit ? (cnt_reg - CNT_W'(8)) : cnt_reg;
        lst1 = emit ? (lst_reg >> 1) : lst_reg;
        opn1 = emit ? (opn_reg >> 1) : opn_reg;
        fin1 = emit ? (fin_reg >> 1) : fin_reg;

        wmask  = ((CODE_W+1)'(1) << code_in.width) - (CODE_W+1)'(1);
        code_m = code_in.value & wmask[CODE_W-1:0];
        sum    = cnt1 + CNT_W'(code_in.width);
        cnt2   = code_in.eof ? ((sum + CNT_W'(7)) & ~CNT_W'(7)) : sum;
        nb1    = cnt1[5:3];
        nb2    = cnt2[5:3];
        opn_base = grp_open_reg ? opn1 : '0;

        acc_next      = acc1;
        cnt_next      = cnt1;
        lst_next      = lst1;
        opn_next      = opn1;
        fin_next      = fin1;
        grp_open_next = grp_open_reg;
        new_b         = 1'b0;

        if (take) begin
            acc_next      = acc1 | (ACC_W'(code_m) << cnt1);
            cnt_next      = cnt2;
            grp_open_next = !code_in.last;
            for (int b = 0; b < ACC_BYTES; b++) begin
                new_b = (3'(b) >= nb1) && (3'(b) < nb2);
                if (nb2 > nb1) begin
                    if (3'(b) == nb2 - 3'd1) begin
                        lst_next[b] = 1'b1;
                    end else if (opn_base[b]) begin
                        lst_next[b] = 1'b0;
                    end
                end
                opn_next[b] = code_in.last ? 1'b0 : (opn_base[b] | new_b);
                fin_next[b] = fin1[b] | (code_in.eof && (3'(b) == nb2 - 3'd1));
            end
        end

        sc1          = sub_cnt_reg + 8'd1;
        sub_cnt_next = sub_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        byte_next    = byte_reg;
        sub_next     = sub_reg;
        send_next    = send_reg;
        rlast_next   = rlast_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            byte_next    = acc_reg[7:0];
            sub_next     = (sc1 == SUB_LEN);
            send_next    = fin_reg[0];
            rlast_next   = lst_reg[0];
            sub_cnt_next = (fin_reg[0] || sc1 == SUB_LEN) ? 8'd0 : sc1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            cnt_reg      <= '0;
            lst_reg      <= '0;
            opn_reg      <= '0;
            fin_reg      <= '0;
            grp_open_reg <= 1'b0;
            sub_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            lst_reg      <= lst_next;
            opn_reg      <= opn_next;
            fin_reg      <= fin_next;
            grp_open_reg <= grp_open_next;
            sub_cnt_reg  <= sub_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        sub_reg   <= sub_next;
        send_reg  <= send_next;
        rlast_reg <= rlast_next;
    end

endmodule
